[hdl/spm_pkg.sv]
// Package for the stereo pan mixer: transaction payload types, register
// indexes, pipeline enable struct and pan gain helpers.
// No dependencies.
package spm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = 32;
    localparam int TERM_W   = 48;
    localparam int ACC_W    = 50;
    localparam int FRAC_SH  = 30;
    localparam int NUM_CH   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_0    = 3'd4;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN = 16'h8000;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 50'sd536870912;
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_0;
        logic signed [SAMPLE_W-1:0] sample_1;
        logic signed [SAMPLE_W-1:0] sample_2;
        logic signed [SAMPLE_W-1:0] sample_3;
        logic [NUM_CH-1:0]          channel_active;
        logic                       last_frame;
    } t_mix_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       last_frame_out;
        logic                       clipped;
    } t_mix_out;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    // Left factor is unity minus the leftward pan magnitude; it never exceeds unity.
    function automatic logic [GAIN_W-1:0] pan_left(input logic signed [GAIN_W-1:0] pan);
        logic [GAIN_W-1:0] f;
        f = UNITY_GAIN;
        if (pan < 0) begin
            f = UNITY_GAIN + pan;
        end
        return f;
    endfunction

    function automatic logic [GAIN_W-1:0] pan_right(input logic signed [GAIN_W-1:0] pan);
        logic [GAIN_W-1:0] f;
        f = UNITY_GAIN;
        if (pan > 0) begin
            f = UNITY_GAIN - pan;
        end
        return f;
    endfunction

endpackage

[hdl/spm_lane.sv]
// One mixer lane: sample times volume, then times the left and right pan factors.
// Two pipeline stages. Depends on spm_pkg.
module spm_lane
    import spm_pkg::*;
(
    input  logic                        i_clk,
    input  t_stage_en                   i_en,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    input  logic                        i_active,
    input  logic [GAIN_W-1:0]           i_volume,
    input  logic signed [GAIN_W-1:0]    i_pan,
    output logic signed [TERM_W-1:0]    o_term_l,
    output logic signed [TERM_W-1:0]    o_term_r
);

    logic signed [PROD_W-1:0]   r_prod;
    logic [GAIN_W-1:0]          r_fl;
    logic [GAIN_W-1:0]          r_fr;
    logic signed [TERM_W-1:0]   r_term_l;
    logic signed [TERM_W-1:0]   r_term_r;
    logic signed [PROD_W:0]     w_prod_full;
    logic signed [PROD_W+GAIN_W+1:0] w_full_l;
    logic signed [PROD_W+GAIN_W+1:0] w_full_r;

    assign w_prod_full = i_sample * $signed({1'b0, i_volume});
    assign w_full_l    = r_prod * $signed({1'b0, r_fl});
    assign w_full_r    = r_prod * $signed({1'b0, r_fr});

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod <= i_active ? w_prod_full[PROD_W-1:0] : '0;
            r_fl   <= pan_left(i_pan);
            r_fr   <= pan_right(i_pan);
        end
        if (i_en.s2) begin
            r_term_l <= w_full_l[TERM_W-1:0];
            r_term_r <= w_full_r[TERM_W-1:0];
        end
    end

    assign o_term_l = r_term_l;
    assign o_term_r = r_term_r;

endmodule

[hdl/spm_merge.sv]
// Merging stage: sums the lane terms, then rounds and saturates into the
// output register. Depends on spm_pkg.
module spm_merge
    import spm_pkg::*;
#(
    parameter int N = 4
) (
    input  logic                        i_clk,
    input  t_stage_en                   i_en,
    input  logic signed [TERM_W-1:0]    i_term_l [N],
    input  logic signed [TERM_W-1:0]    i_term_r [N],
    input  logic                        i_last,
    output t_mix_out                    o_result
);

    localparam int RND_W = ACC_W - FRAC_SH;

    logic signed [ACC_W-1:0]    r_sum_l;
    logic signed [ACC_W-1:0]    r_sum_r;
    logic signed [ACC_W-1:0]    n_sum_l;
    logic signed [ACC_W-1:0]    n_sum_r;
    logic                       r_last;
    t_mix_out                   r_result;
    logic signed [ACC_W-1:0]    w_sh_l;
    logic signed [ACC_W-1:0]    w_sh_r;
    logic signed [RND_W-1:0]    w_rnd_l;
    logic signed [RND_W-1:0]    w_rnd_r;
    logic signed [SAMPLE_W-1:0] w_left;
    logic signed [SAMPLE_W-1:0] w_right;
    logic                       w_clip_l;
    logic                       w_clip_r;

    always_comb begin
        n_sum_l = '0;
        n_sum_r = '0;
        for (int i = 0; i < N; i++) begin
            n_sum_l = n_sum_l + ACC_W'(i_term_l[i]);
            n_sum_r = n_sum_r + ACC_W'(i_term_r[i]);
        end
    end

    assign w_sh_l  = (r_sum_l + ROUND_HALF) >>> FRAC_SH;
    assign w_sh_r  = (r_sum_r + ROUND_HALF) >>> FRAC_SH;
    assign w_rnd_l = w_sh_l[RND_W-1:0];
    assign w_rnd_r = w_sh_r[RND_W-1:0];

    always_comb begin
        w_clip_l = 1'b0;
        w_clip_r = 1'b0;
        w_left   = w_rnd_l[SAMPLE_W-1:0];
        w_right  = w_rnd_r[SAMPLE_W-1:0];
        if (w_rnd_l > RND_W'(SAT_MAX)) begin
            w_left   = SAT_MAX;
            w_clip_l = 1'b1;
        end else if (w_rnd_l < RND_W'(SAT_MIN)) begin
            w_left   = SAT_MIN;
            w_clip_l = 1'b1;
        end
        if (w_rnd_r > RND_W'(SAT_MAX)) begin
            w_right  = SAT_MAX;
            w_clip_r = 1'b1;
        end else if (w_rnd_r < RND_W'(SAT_MIN)) begin
            w_right  = SAT_MIN;
            w_clip_r = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sum_l <= n_sum_l;
            r_sum_r <= n_sum_r;
            r_last  <= i_last;
        end
        if (i_en.s4) begin
            r_result.left_out       <= w_left;
            r_result.right_out      <= w_right;
            r_result.last_frame_out <= r_last;
            r_result.clipped        <= w_clip_l | w_clip_r;
        end
    end

    assign o_result = r_result;

endmodule

[hdl/stereo_pan_mixer.sv]
// Top level of the stereo pan mixer: configuration registers, pipeline
// control and the lane and merge instances. Depends on spm_pkg, spm_lane, spm_merge.
//
// Usage:
// A frame transaction on the input channel (i_valid, o_stall, i_frame) carries
// four signed samples, a channel_active mask and a last_frame marker. Each
// active channel is scaled by its volume and by its left and right pan
// factors; the two sums are rounded and saturated to signed 16 bits and
// leave as one transaction on the output channel (o_valid, i_stall, o_result).
// There are four register stages: the lane product, the lane terms, the sum
// and the result register, which offers the frame on the output channel.
// Throughput is one frame per clock while the receiver does not stall; the two
// multiplier stages of each lane and the sum and round stages then all advance.
// When the receiver stalls, the result holds, and stages behind it keep
// filling any empty slots before the input channel stalls.
// The user must write the registers through i_cfg_we, i_cfg_idx and i_cfg_data
// only while the block is idle; the block does not enforce this. Synchronous
// reset clears the volume and pan registers to zero and empties the pipeline.
module stereo_pan_mixer
    import spm_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [GAIN_W-1:0]       i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_mix_in                 i_frame,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_mix_out                o_result
);

    logic [GAIN_W-1:0]          r_volume [NUM_CH];
    logic signed [GAIN_W-1:0]   r_pan    [NUM_CH];
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       r_vo;
    logic                       r_last1;
    logic                       r_last2;
    t_stage_en                  w_en;
    logic signed [SAMPLE_W-1:0] w_sample [NUM_CH];
    logic signed [TERM_W-1:0]   w_term_l [CHANNELS];
    logic signed [TERM_W-1:0]   w_term_r [CHANNELS];

    assign w_en.s4 = !r_vo || !i_stall;
    assign w_en.s3 = !r_v3 || w_en.s4;
    assign w_en.s2 = !r_v2 || w_en.s3;
    assign w_en.s1 = !r_v1 || w_en.s2;
    assign o_stall = !w_en.s1;
    assign o_valid = r_vo;

    assign w_sample[0] = i_frame.sample_0;
    assign w_sample[1] = i_frame.sample_1;
    assign w_sample[2] = i_frame.sample_2;
    assign w_sample[3] = i_frame.sample_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_volume[c] <= '0;
                r_pan[c]    <= '0;
            end
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx >= REG_PAN_0) begin
                    r_pan[i_cfg_idx[1:0]] <= i_cfg_data;
                end else begin
                    r_volume[i_cfg_idx[1:0]] <= i_cfg_data;
                end
            end
            if (w_en.s1) r_v1 <= i_valid;
            if (w_en.s2) r_v2 <= r_v1;
            if (w_en.s3) r_v3 <= r_v2;
            if (w_en.s4) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en.s1) r_last1 <= i_frame.last_frame;
        if (w_en.s2) r_last2 <= r_last1;
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        spm_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_sample (w_sample[c]),
            .i_active (i_frame.channel_active[c]),
            .i_volume (r_volume[c]),
            .i_pan    (r_pan[c]),
            .o_term_l (w_term_l[c]),
            .o_term_r (w_term_r[c])
        );
    end

    spm_merge #(
        .N (CHANNELS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_term_l (w_term_l),
        .i_term_r (w_term_r),
        .i_last   (r_last2),
        .o_result (o_result)
    );

endmodule

[hdl/spm_checker.sv]
// Port-level checker for the stereo pan mixer and its bind to the top level.
// Depends on spm_pkg and stereo_pan_mixer.
module spm_checker
    import spm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  t_mix_out    o_result
);

    logic w_in_acc;

    assign w_in_acc = i_valid && !o_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("Stalled output transaction changed.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("Accepted frame did not reach the output in four cycles.");

    a_clip_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.clipped |->
            o_result.left_out == SAT_MAX || o_result.left_out == SAT_MIN ||
            o_result.right_out == SAT_MAX || o_result.right_out == SAT_MIN)
        else $error("Clipped flag without a saturated output.");

endmodule

bind stereo_pan_mixer spm_checker u_spm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);

[sim/spm_mix_checker.sv]
// Checker for the stereo pan mixer: follows the register port, predicts each
// mixed stereo pair and compares it with what leaves the block.
// Depends on spm_pkg.
`timescale 1ns / 100ps

module spm_mix_checker
    import spm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_mix_in              i_frame,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_mix_out             i_result,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_clips
);

    logic [GAIN_W-1:0]          vol_q [NUM_CH];
    logic signed [GAIN_W-1:0]   pan_q [NUM_CH];
    t_mix_out                   expected_mix [$];
    t_mix_out                   want;
    t_mix_out                   got;

    function automatic logic signed [SAMPLE_W-1:0] round_clip(input longint acc,
                                                              inout logic clip);
        longint r;
        r = (acc + (64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH;
        if (r > 32767) begin
            clip = 1'b1;
            return SAT_MAX;
        end
        if (r < -32768) begin
            clip = 1'b1;
            return SAT_MIN;
        end
        return SAMPLE_W'(r);
    endfunction

    function automatic t_mix_out mix_frame(input t_mix_in f);
        logic signed [SAMPLE_W-1:0] smp [NUM_CH];
        longint sum_l;
        longint sum_r;
        longint p;
        longint fl;
        longint fr;
        logic clip;
        t_mix_out m;
        smp[0] = f.sample_0;
        smp[1] = f.sample_1;
        smp[2] = f.sample_2;
        smp[3] = f.sample_3;
        sum_l = 0;
        sum_r = 0;
        clip = 1'b0;
        for (int c = 0; c < NUM_CH; c++) begin
            if (f.channel_active[c]) begin
                p = longint'(pan_q[c]);
                fl = 32768 - ((p < 0) ? -p : 0);
                fr = 32768 - ((p > 0) ? p : 0);
                sum_l += longint'(smp[c]) * longint'(vol_q[c]) * fl;
                sum_r += longint'(smp[c]) * longint'(vol_q[c]) * fr;
            end
        end
        m.left_out = round_clip(sum_l, clip);
        m.right_out = round_clip(sum_r, clip);
        m.last_frame_out = f.last_frame;
        m.clipped = clip;
        return m;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
        o_clips = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                vol_q[c] = '0;
                pan_q[c] = '0;
            end
            expected_mix.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx >= REG_PAN_0) begin
                    pan_q[i_cfg_idx - REG_PAN_0] = i_cfg_data;
                end else begin
                    vol_q[i_cfg_idx - REG_VOLUME_0] = i_cfg_data;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_result;
                if (expected_mix.size() == 0) begin
                    $error("result transaction with no frame outstanding: left %0d right %0d",
                           got.left_out, got.right_out);
                    o_errors++;
                end else begin
                    want = expected_mix.pop_front();
                    o_results++;
                    if (got.clipped) begin
                        o_clips++;
                    end
                    if (got.left_out !== want.left_out) begin
                        $error("left_out mismatch: expected %0d, actual %0d",
                               want.left_out, got.left_out);
                        o_errors++;
                    end
                    if (got.right_out !== want.right_out) begin
                        $error("right_out mismatch: expected %0d, actual %0d",
                               want.right_out, got.right_out);
                        o_errors++;
                    end
                    if (got.last_frame_out !== want.last_frame_out) begin
                        $error("last_frame_out mismatch: expected %0d, actual %0d",
                               want.last_frame_out, got.last_frame_out);
                        o_errors++;
                    end
                    if (got.clipped !== want.clipped) begin
                        $error("clipped mismatch: expected %0d, actual %0d",
                               want.clipped, got.clipped);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_mix.insert(expected_mix.size(), mix_frame(i_frame));
            end
        end
        o_pending = expected_mix.size();
    end

endmodule

[sim/stereo_pan_mixer_test.sv]
// Testbench top for the stereo pan mixer: clock, reset, register setup and
// frame stimulus under several idle and stall patterns, plus the verdict.
// Depends on spm_pkg, stereo_pan_mixer and spm_mix_checker.
`timescale 1ns / 100ps

module stereo_pan_mixer_test;
    import spm_pkg::*;

    localparam int LIMIT = 400000;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_ITEMS = 125;
    localparam int LONG_HOLD = 200;
    localparam int SETTLE = 8;
    localparam logic [GAIN_W-1:0] DIR_VOL [NUM_CH] = '{16'hFFFF, 16'h8000, 16'h4000, 16'h8000};
    localparam logic [GAIN_W-1:0] DIR_PAN [NUM_CH] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hC000};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [GAIN_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    t_mix_in              i_frame;
    logic                 o_valid;
    logic                 i_stall;
    t_mix_out             o_result;

    int mix_errors;
    int mix_pending;
    int mix_results;
    int mix_clips;
    int send_idle_pct;
    int stall_pct;
    int cycles;
    int settings_done;
    logic hold_req;

    stereo_pan_mixer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_frame    (i_frame),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

    spm_mix_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_frame     (i_frame),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_result    (o_result),
        .o_errors    (mix_errors),
        .o_pending   (mix_pending),
        .o_results   (mix_results),
        .o_clips     (mix_clips)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1: return SAMPLE_W'(int'($urandom_range(512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic t_mix_in rand_frame();
        t_mix_in f;
        f.sample_0 = pick_sample();
        f.sample_1 = pick_sample();
        f.sample_2 = pick_sample();
        f.sample_3 = pick_sample();
        f.channel_active = NUM_CH'($urandom_range(15));
        f.last_frame = 1'($urandom_range(1));
        return f;
    endfunction

    function automatic t_mix_in frame_of(input int s0, input int s1, input int s2,
                                         input int s3, input int act, input int last);
        t_mix_in f;
        f.sample_0 = SAMPLE_W'(s0);
        f.sample_1 = SAMPLE_W'(s1);
        f.sample_2 = SAMPLE_W'(s2);
        f.sample_3 = SAMPLE_W'(s3);
        f.channel_active = NUM_CH'(act);
        f.last_frame = 1'(last);
        return f;
    endfunction

    task automatic send_frame(input t_mix_in f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_frame <= rand_frame();
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_frame <= f;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_out();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (mix_pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic load_setting(input int k);
        logic [GAIN_W-1:0] v;
        logic [GAIN_W-1:0] p;
        for (int c = 0; c < NUM_CH; c++) begin
            case (k)
                0: begin
                    v = DIR_VOL[c];
                    p = DIR_PAN[c];
                end
                1: begin
                    v = '0;
                    p = '0;
                end
                2: begin
                    v = UNITY_GAIN;
                    p = '0;
                end
                3: begin
                    v = '1;
                    p = 16'h8000;
                end
                4: begin
                    v = '1;
                    p = 16'h7FFF;
                end
                default: begin
                    v = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(65535))
                                                 : GAIN_W'($urandom_range(32768));
                    p = GAIN_W'($urandom);
                end
            endcase
            write_reg(REG_VOLUME_0 + CFG_IDX_W'(c), v);
            write_reg(REG_PAN_0 + CFG_IDX_W'(c), p);
        end
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_frame = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        settings_done = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_setting(0);
        send_frame(frame_of(32767, 32767, 32767, 32767, 15, 0));
        send_frame(frame_of(-32768, -32768, -32768, -32768, 15, 1));
        send_frame(frame_of(32767, -32768, 32767, -32768, 0, 1));
        send_frame(frame_of(0, 0, 0, 0, 15, 0));
        for (int c = 0; c < NUM_CH; c++) begin
            send_frame(frame_of(-32768, -32768, -32768, -32768, 1 << c, c & 1));
            send_frame(frame_of(32767, 32767, 32767, 32767, 1 << c, 0));
        end
        send_frame(frame_of(0, 0, 1, 0, 4, 0));
        send_frame(frame_of(0, 0, -1, 0, 4, 1));
        send_frame(frame_of(0, 0, 3, 0, 4, 0));
        send_frame(frame_of(0, 0, -3, 0, 4, 0));
        send_frame(frame_of(12345, -23456, 777, -5, 15, 0));
        send_frame(frame_of(-1, 1, -32768, 32767, 10, 1));
        send_frame(frame_of(100, -200, 300, -400, 5, 0));

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            drain_out();
            load_setting(ph);
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 73;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 73;
                end
                default: begin
                    send_idle_pct = 37;
                    stall_pct = 37;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && ph % 3 == 1) begin
                    send_idle_pct = 0;
                    hold_req = 1'b1;
                end
                if (n == PHASE_ITEMS / 2 && ph % 3 == 2) begin
                    drain_out();
                end
                send_frame(rand_frame());
            end
        end

        stall_pct = 0;
        drain_out();
        $display("Mixed %0d frames under %0d register settings, %0d of them clipped.",
                 mix_results, settings_done, mix_clips);
        $display("Covered free flow, sender gaps, receiver stalls, both, and a long hold-off.");
        if (mix_errors == 0 && mix_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/spm_pkg.sv
hdl/spm_lane.sv
hdl/spm_merge.sv
hdl/stereo_pan_mixer.sv
hdl/spm_checker.sv
sim/spm_mix_checker.sv
sim/stereo_pan_mixer_test.sv
